### rtl/saa_pkg.sv
// ----------------------------------------------------------------------------
// saa_pkg
// shared types, codes and defaults of the skyline atlas allocator
// ----------------------------------------------------------------------------
package saa_pkg;

  parameter int DEF_ATLAS_WIDTH  = 256;
  parameter int DEF_ATLAS_HEIGHT = 256;
  parameter int DEF_MAX_PAGES    = 128;

  parameter int REQ_DIM_BITS = 9;
  parameter int POS_BITS     = 8;
  parameter int PAGE_BITS    = 7;
  parameter int STATUS_BITS  = 2;
  parameter int S_DATA_BITS  = 24;
  parameter int M_DATA_BITS  = 24;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_PLACED    = 2'd0,
    ST_NEW_PAGE  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_CMP,
    S_BACK,
    S_WIN,
    S_FRONT,
    S_DECIDE,
    S_FILL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_req;
    logic scan_init;
    logic pop_back;
    logic load_back;
    logic push;
    logic pop_front;
    logic load_front;
    logic eval;
    logic j_inc;
    logic res_restart;
    logic res_too_large;
    logic res_placed;
    logic res_newpage;
    logic res_exhausted;
    logic fill_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_restart;
    logic too_large;
    logic dq_nonempty;
    logic back_le;
    logic count_gt1;
    logic front_stale;
    logic at_window;
    logic last_col;
    logic fits;
    logic pages_full;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/saa_ram.sv
// ----------------------------------------------------------------------------
// saa_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module saa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/saa_ctrl.sv
// ----------------------------------------------------------------------------
// saa_ctrl
// sequencer for request capture, skyline scan, fill and result handoff
// ----------------------------------------------------------------------------
module saa_ctrl
  import saa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_req = 1'b1;
          state_next   = S_START;
        end
      end
      S_START: begin
        priority if (sts.is_restart) begin
          cmd.res_restart = 1'b1;
          state_next      = S_OUT;
        end else if (sts.too_large) begin
          cmd.res_too_large = 1'b1;
          state_next        = S_OUT;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.dq_nonempty && sts.back_le) begin
          cmd.pop_back = 1'b1;
          state_next   = sts.count_gt1 ? S_BACK : S_CMP;
        end else begin
          cmd.push = 1'b1;
          if (sts.at_window) begin
            state_next = S_WIN;
          end else begin
            cmd.j_inc  = 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_BACK: begin
        cmd.load_back = 1'b1;
        state_next    = S_CMP;
      end
      S_WIN: begin
        if (sts.front_stale) begin
          cmd.pop_front = 1'b1;
          state_next    = S_FRONT;
        end else begin
          cmd.eval = 1'b1;
          if (sts.last_col) begin
            state_next = S_DECIDE;
          end else begin
            cmd.j_inc  = 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_FRONT: begin
        cmd.load_front = 1'b1;
        state_next     = S_WIN;
      end
      S_DECIDE: begin
        priority if (sts.fits) begin
          cmd.res_placed = 1'b1;
          state_next     = S_FILL;
        end else if (sts.pages_full) begin
          cmd.res_exhausted = 1'b1;
          state_next        = S_OUT;
        end else begin
          cmd.res_newpage = 1'b1;
          state_next      = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/saa_dp.sv
// ----------------------------------------------------------------------------
// saa_dp
// skyline store, sliding-window maximum queue, best-fit tracking and result
// registers
// ----------------------------------------------------------------------------
module saa_dp
  import saa_pkg::*;
#(
  parameter int ATLAS_WIDTH  = DEF_ATLAS_WIDTH,
  parameter int ATLAS_HEIGHT = DEF_ATLAS_HEIGHT,
  parameter int MAX_PAGES    = DEF_MAX_PAGES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [S_DATA_BITS-1:0] s_tdata,
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_BITS-1:0] m_tdata,
  output logic [STATUS_BITS-1:0] m_tuser
);

  localparam int CW = $clog2(ATLAS_WIDTH);
  localparam int HW = $clog2(ATLAS_HEIGHT + 1);
  localparam int PW = $clog2(MAX_PAGES + 1);
  localparam int QW = HW + CW;

  logic                    req_func;
  logic [REQ_DIM_BITS-1:0] req_w;
  logic [REQ_DIM_BITS-1:0] req_h;
  logic [CW-1:0]           w_c;
  logic [HW-1:0]           h_c;

  logic [CW-1:0] j;
  logic [CW-1:0] head;
  logic [CW-1:0] tail;
  logic [CW-1:0] count;
  logic [HW-1:0] front_h;
  logic [CW-1:0] front_i;
  logic [HW-1:0] back_h;
  logic [HW-1:0] lowest;
  logic [CW-1:0] best_x;
  logic [CW-1:0] win_start;

  logic [PW-1:0]    page;
  logic [CW-1:0]    res_x;
  logic [HW-1:0]    res_y;
  status_t          res_st;
  logic [CW-1:0]    fill_addr;
  logic [HW-1:0]    fill_val;
  logic [CW-1:0]    fill_k;

  logic [ATLAS_WIDTH-1:0] sky_vld;
  logic                   sky_vld_q;
  logic [HW-1:0]          sky_rdata;
  logic [HW-1:0]          sky_h;

  logic [CW-1:0] dq_raddr;
  logic [QW-1:0] dq_rdata;

  logic [POS_BITS-1:0]  out_x;
  logic [POS_BITS-1:0]  out_y;
  logic [PAGE_BITS-1:0] out_page;
  status_t              out_st;

  assign w_c       = CW'(req_w);
  assign h_c       = HW'(req_h);
  assign sky_h     = sky_vld_q ? sky_rdata : '0;
  assign win_start = j - (w_c - CW'(1));
  assign dq_raddr  = cmd.pop_front ? head + CW'(1) : tail - CW'(2);

  saa_ram #(
    .WIDTH(HW),
    .DEPTH(ATLAS_WIDTH)
  ) u_sky (
    .clk  (clk),
    .we   (cmd.fill_wr),
    .waddr(fill_addr),
    .wdata(fill_val),
    .raddr(j),
    .rdata(sky_rdata)
  );

  saa_ram #(
    .WIDTH(QW),
    .DEPTH(2 ** CW)
  ) u_queue (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(tail),
    .wdata({sky_h, j}),
    .raddr(dq_raddr),
    .rdata(dq_rdata)
  );

  always_comb begin
    sts.is_restart  = (req_func == FUNC_RESTART);
    sts.too_large   = (req_w == '0) || (req_h == '0)
                      || (32'(req_w) >= 32'(ATLAS_WIDTH))
                      || (32'(req_h) > 32'(ATLAS_HEIGHT));
    sts.dq_nonempty = (count != '0);
    sts.back_le     = (back_h <= sky_h);
    sts.count_gt1   = (count > CW'(1));
    sts.front_stale = ((CW+1)'(front_i) + (CW+1)'(w_c)) <= (CW+1)'(j);
    sts.at_window   = (j >= (w_c - CW'(1)));
    sts.last_col    = (j == CW'(ATLAS_WIDTH - 2));
    sts.fits        = ((HW+1)'(lowest) + (HW+1)'(h_c)) <= (HW+1)'(ATLAS_HEIGHT);
    sts.pages_full  = ((PW+1)'(page) + (PW+1)'(1)) >= (PW+1)'(MAX_PAGES);
    sts.fill_last   = (fill_k == (w_c - CW'(1)));
    sts.out_free    = !m_tvalid || m_tready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      page     <= '0;
      sky_vld  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.res_restart) begin
        page    <= '0;
        sky_vld <= '0;
      end else if (cmd.res_newpage) begin
        page    <= page + PW'(1);
        sky_vld <= '0;
      end else if (cmd.fill_wr) begin
        sky_vld[fill_addr] <= 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sky_vld_q <= sky_vld[j];
    if (cmd.load_req) begin
      req_func <= s_tuser[0];
      req_w    <= s_tdata[REQ_DIM_BITS-1:0];
      req_h    <= s_tdata[2*REQ_DIM_BITS-1:REQ_DIM_BITS];
    end
    if (cmd.scan_init) begin
      j      <= '0;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      lowest <= HW'(ATLAS_HEIGHT);
      best_x <= '0;
    end
    if (cmd.j_inc) begin
      j <= j + CW'(1);
    end
    if (cmd.pop_back) begin
      tail  <= tail - CW'(1);
      count <= count - CW'(1);
    end
    if (cmd.load_back) begin
      back_h <= dq_rdata[QW-1:CW];
    end
    if (cmd.push) begin
      tail   <= tail + CW'(1);
      count  <= count + CW'(1);
      back_h <= sky_h;
      if (count == '0) begin
        front_h <= sky_h;
        front_i <= j;
      end
    end
    if (cmd.pop_front) begin
      head  <= head + CW'(1);
      count <= count - CW'(1);
    end
    if (cmd.load_front) begin
      front_h <= dq_rdata[QW-1:CW];
      front_i <= dq_rdata[CW-1:0];
    end
    if (cmd.eval && (front_h < lowest)) begin
      lowest <= front_h;
      best_x <= win_start;
    end
    if (cmd.res_restart) begin
      res_x  <= '0;
      res_y  <= '0;
      res_st <= ST_PLACED;
    end
    if (cmd.res_too_large) begin
      res_x  <= '0;
      res_y  <= '0;
      res_st <= ST_TOO_LARGE;
    end
    if (cmd.res_exhausted) begin
      res_x  <= '0;
      res_y  <= '0;
      res_st <= ST_EXHAUSTED;
    end
    if (cmd.res_placed) begin
      res_x     <= best_x;
      res_y     <= lowest;
      res_st    <= ST_PLACED;
      fill_addr <= best_x;
      fill_val  <= lowest + h_c;
      fill_k    <= '0;
    end
    if (cmd.res_newpage) begin
      res_x     <= '0;
      res_y     <= '0;
      res_st    <= ST_NEW_PAGE;
      fill_addr <= '0;
      fill_val  <= h_c;
      fill_k    <= '0;
    end
    if (cmd.fill_wr) begin
      fill_addr <= fill_addr + CW'(1);
      fill_k    <= fill_k + CW'(1);
    end
    if (cmd.out_load) begin
      out_x    <= POS_BITS'(res_x);
      out_y    <= POS_BITS'(res_y);
      out_page <= PAGE_BITS'(page);
      out_st   <= res_st;
    end
  end

  assign m_tdata = M_DATA_BITS'({out_page, out_y, out_x});
  assign m_tuser = out_st;

endmodule

### rtl/skyline_atlas_allocator.sv
// ----------------------------------------------------------------------------
// skyline_atlas_allocator
// skyline rectangle packer over fixed-size atlas pages
//
//   channel  dir  tdata                              tuser
//   s_*      in   rect_width[8:0] rect_height[17:9]  func[0]
//   m_*      out  pos_x[7:0] pos_y[15:8] page[22:16] status[1:0]
//
// allocate: the scan reads and compares each of ATLAS_WIDTH-1 columns, passes
// through S_WIN for each column that closes a window and may pass through
// S_BACK or S_FRONT for each entry dropped from the window-max queue, then
// writes rect_width fill columns before the result goes to the output register
// restart and too-large requests skip the scan and the fill
// reset returns to idle on page 0 with every skyline column cleared at once
// one request at a time; a result waits in the output register under stall
// ----------------------------------------------------------------------------
module skyline_atlas_allocator
  import saa_pkg::*;
#(
  parameter int ATLAS_WIDTH  = DEF_ATLAS_WIDTH,
  parameter int ATLAS_HEIGHT = DEF_ATLAS_HEIGHT,
  parameter int MAX_PAGES    = DEF_MAX_PAGES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_DATA_BITS-1:0] s_tdata,   // rect_width, rect_height
  input  logic [0:0]             s_tuser,   // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_BITS-1:0] m_tdata,   // pos_x, pos_y, page
  output logic [STATUS_BITS-1:0] m_tuser    // status
);

  cmd_t cmd;
  sts_t sts;

  saa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (s_tvalid && s_tready),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  saa_dp #(
    .ATLAS_WIDTH (ATLAS_WIDTH),
    .ATLAS_HEIGHT(ATLAS_HEIGHT),
    .MAX_PAGES   (MAX_PAGES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the skyline atlas allocator
//
// requests go in on the s_* stream and placements come back on m_*. a
// behavioral skyline with its own page counter predicts every placement when
// the request beat is taken, and each result beat is checked against the
// oldest prediction. tests: directed corners, back-to-back traffic, running
// the page counter to exhaustion, then long random packing with random stalls
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import saa_pkg::*;

  localparam int ATLAS_W     = DEF_ATLAS_WIDTH;
  localparam int ATLAS_H     = DEF_ATLAS_HEIGHT;
  localparam int MAX_PG      = DEF_MAX_PAGES;
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [POS_BITS-1:0]  pos_x;
    logic [POS_BITS-1:0]  pos_y;
    logic [PAGE_BITS-1:0] page;
    status_t              st;
  } placement_t;

  logic                   clk;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_BITS-1:0] s_tdata  = '0;
  logic [0:0]             s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_tdata;
  logic [STATUS_BITS-1:0] m_tuser;

  int         col_top [ATLAS_W];
  int         page_idx;
  placement_t placement_q [$];

  bit idle_in  = 1'b1;
  bit idle_out = 1'b1;
  int out_hold = 0;
  int cycles   = 0;
  int errors   = 0;
  int n_sent   = 0;
  int n_results = 0;
  int n_restarts = 0;
  int status_hits [4];

  skyline_atlas_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_skyline();
    foreach (col_top[i]) col_top[i] = 0;
  endfunction

  // first start column whose tallest spanned column is strictly the lowest
  function automatic bit skyline_fit(input int w, input int h, output int px, output int py);
    int  lowest;
    int  top;
    int  found_x;
    int  s;
    int  k;
    bit  found;
    bit  ok;
    lowest  = ATLAS_H;
    found_x = 0;
    found   = 1'b0;
    px      = 0;
    py      = 0;
    for (s = 0; s + w < ATLAS_W; s++) begin
      top = 0;
      ok  = 1'b1;
      for (k = 0; k < w; k++) begin
        if (col_top[s+k] >= lowest) begin
          ok = 1'b0;
          break;
        end
        if (col_top[s+k] > top) top = col_top[s+k];
      end
      if (ok) begin
        found   = 1'b1;
        found_x = s;
        lowest  = top;
      end
    end
    if (!found || lowest + h > ATLAS_H) return 1'b0;
    for (k = 0; k < w; k++) col_top[found_x+k] = lowest + h;
    px = found_x;
    py = lowest;
    return 1'b1;
  endfunction

  function automatic placement_t skyline_predict(input logic fn, input logic [8:0] w,
                                                 input logic [8:0] h);
    placement_t p;
    status_t    st;
    int         px;
    int         py;
    int         wi;
    int         hi;
    px = 0;
    py = 0;
    wi = int'(w);
    hi = int'(h);
    if (fn == FUNC_RESTART) begin
      clear_skyline();
      page_idx = 0;
      st = ST_PLACED;
    end else if (wi == 0 || hi == 0 || wi >= ATLAS_W || hi > ATLAS_H) begin
      st = ST_TOO_LARGE;
    end else if (skyline_fit(wi, hi, px, py)) begin
      st = ST_PLACED;
    end else if (page_idx + 1 >= MAX_PG) begin
      st = ST_EXHAUSTED;
      px = 0;
      py = 0;
    end else begin
      page_idx++;
      clear_skyline();
      void'(skyline_fit(wi, hi, px, py));
      st = ST_NEW_PAGE;
    end
    p.pos_x = px[POS_BITS-1:0];
    p.pos_y = py[POS_BITS-1:0];
    p.page  = page_idx[PAGE_BITS-1:0];
    p.st    = st;
    return p;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic void draw_request(output logic fn, output logic [8:0] w,
                                       output logic [8:0] h);
    int r;
    r  = $urandom_range(0, 99);
    fn = FUNC_ALLOC;
    if (r < 2) begin
      fn = FUNC_RESTART;
      w  = 9'($urandom_range(0, 511));
      h  = 9'($urandom_range(0, 511));
    end else if (r < 6) begin
      w = 9'($urandom_range(1, 255));
      h = 9'($urandom_range(1, 256));
      case ($urandom_range(0, 3))
        0:       w = 9'd0;
        1:       h = 9'd0;
        2:       w = 9'($urandom_range(256, 511));
        default: h = 9'($urandom_range(257, 511));
      endcase
    end else if (r < 80) begin
      w = 9'($urandom_range(1, 48));
      h = 9'($urandom_range(1, 48));
    end else if (r < 95) begin
      w = 9'($urandom_range(1, 160));
      h = 9'($urandom_range(1, 160));
    end else begin
      w = 9'($urandom_range(200, 255));
      h = 9'($urandom_range(200, 256));
    end
  endfunction

  // valid stays high across back-to-back beats
  task automatic send_req(input logic fn, input logic [8:0] w, input logic [8:0] h);
    int gap;
    gap = idle_in ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {{(S_DATA_BITS-2*REQ_DIM_BITS){1'b0}}, h, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    placement_q.push_back(skyline_predict(fn, w, h));
    n_sent++;
    if (fn == FUNC_RESTART) n_restarts++;
  endtask

  task automatic test_directed();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_req(FUNC_RESTART, 9'h1FF, 9'h1FF);
    send_req(FUNC_ALLOC, 9'd1, 9'd1);
    send_req(FUNC_ALLOC, 9'd255, 9'd1);
    send_req(FUNC_ALLOC, 9'd0, 9'd7);
    send_req(FUNC_ALLOC, 9'd7, 9'd0);
    send_req(FUNC_ALLOC, 9'd256, 9'd1);
    send_req(FUNC_ALLOC, 9'd1, 9'd257);
    send_req(FUNC_ALLOC, 9'h1FF, 9'h1FF);
    send_req(FUNC_ALLOC, 9'd255, 9'd256);
    // rightmost column is never a start column, so this opens a page
    send_req(FUNC_ALLOC, 9'd1, 9'd1);
    send_req(FUNC_ALLOC, 9'd1, 9'd256);
    send_req(FUNC_ALLOC, 9'd300, 9'd3);
    send_req(FUNC_RESTART, 9'd0, 9'd0);
    send_req(FUNC_ALLOC, 9'd128, 9'd128);
    send_req(FUNC_ALLOC, 9'd127, 9'd128);
    send_req(FUNC_ALLOC, 9'd127, 9'd128);
    send_req(FUNC_ALLOC, 9'd1, 9'd128);
    send_req(FUNC_ALLOC, 9'd16, 9'd16);
    send_req(FUNC_ALLOC, 9'd100, 9'd255);
    send_req(FUNC_RESTART, 9'd100, 9'd100);
    send_req(FUNC_ALLOC, 9'd8, 9'd200);
    send_req(FUNC_ALLOC, 9'd4, 9'd56);
    send_req(FUNC_ALLOC, 9'd4, 9'd1);
  endtask

  task automatic test_back_to_back();
    logic       fn;
    logic [8:0] w;
    logic [8:0] h;
    idle_in  = 1'b0;
    idle_out = 1'b0;
    repeat (150) begin
      draw_request(fn, w, h);
      send_req(fn, w, h);
    end
  endtask

  // rectangles too big to share a page walk the page counter to its end
  task automatic test_page_exhaustion();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_req(FUNC_RESTART, 9'd0, 9'd0);
    repeat (MAX_PG + 4)
      send_req(FUNC_ALLOC, 9'($urandom_range(128, 255)), 9'($urandom_range(129, 256)));
    send_req(FUNC_ALLOC, 9'd0, 9'd1);
    send_req(FUNC_ALLOC, 9'd20, 9'd20);
    send_req(FUNC_RESTART, 9'd0, 9'd0);
  endtask

  task automatic test_random_packing();
    logic       fn;
    logic [8:0] w;
    logic [8:0] h;
    int         n;
    for (n = 0; n < 860; n++) begin
      if (n % 100 == 0) begin
        idle_in  = ($urandom_range(0, 3) != 0);
        idle_out = ($urandom_range(0, 3) != 0);
      end
      draw_request(fn, w, h);
      send_req(fn, w, h);
    end
  endtask

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (idle_out) out_hold = pick_gap();
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    placement_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (placement_q.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected beat expected none actual tdata %h tuser %0d",
                   $time, m_tdata, m_tuser);
      end else begin
        want = placement_q.pop_front();
        status_hits[want.st]++;
        check_field("pos_x", int'(want.pos_x), int'(m_tdata[POS_BITS-1:0]));
        check_field("pos_y", int'(want.pos_y), int'(m_tdata[2*POS_BITS-1:POS_BITS]));
        check_field("page", int'(want.page),
                    int'(m_tdata[2*POS_BITS+PAGE_BITS-1:2*POS_BITS]));
        check_field("status", int'(want.st), int'(m_tuser));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, placement_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_page_exhaustion();
    test_random_packing();
    s_tvalid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("%0d requests (%0d restarts) answered by %0d results in %0d cycles",
             n_sent, n_restarts, n_results, cycles);
    $display("placed %0d, new page %0d, too large %0d, pages exhausted %0d",
             status_hits[ST_PLACED], status_hits[ST_NEW_PAGE],
             status_hits[ST_TOO_LARGE], status_hits[ST_EXHAUSTED]);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/saa_pkg.sv
rtl/saa_ram.sv
rtl/saa_ctrl.sv
rtl/saa_dp.sv
rtl/skyline_atlas_allocator.sv
tb/tb_top.sv
